// ===== hw/rtl/c8x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, codes and helper functions for the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_AW        = 5;
    localparam logic [11:0] PC_RESET = 12'd512;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_MEMWR = 2'd1;
    localparam logic [1:0] ACT_ROWRD = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] instruction;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
        logic [7:0]  delay_now;
        logic [11:0] address;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        waiting_key;
        logic        delay_load;
        logic        sound_load;
        logic [7:0]  timer_value;
        logic        screen_changed;
        logic        bad_opcode;
        logic [63:0] row_pixels;
    } t_out_item;

    // Item classes picked by the front end
    typedef enum logic [3:0] {
        CL_NOP, CL_MEMWR, CL_ROWRD, CL_BAD, CL_CLEAR,
        CL_SIMPLE, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE, BS_RDX, BS_RDY, BS_EXEC, BS_DRAW_RD, BS_DRAW_WR,
        BS_BCD, BS_STORE, BS_LOAD_RD, BS_LOAD_WR, BS_DONE
    } t_bstate;

    // Opcode groups (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OPW_CLS = 16'h00E0;
    localparam logic [15:0] OPW_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MSC_GDT  = 8'h07;
    localparam logic [7:0] MSC_WKEY = 8'h0A;
    localparam logic [7:0] MSC_SDT  = 8'h15;
    localparam logic [7:0] MSC_SST  = 8'h18;
    localparam logic [7:0] MSC_ADDI = 8'h1E;
    localparam logic [7:0] MSC_FONT = 8'h29;
    localparam logic [7:0] MSC_BCD  = 8'h33;
    localparam logic [7:0] MSC_STR  = 8'h55;
    localparam logic [7:0] MSC_LDR  = 8'h65;

    // Hundreds digit of a byte
    function automatic logic [7:0] bcd_hund(input logic [7:0] v);
        logic [7:0] h;
        if (v >= 8'd200) h = 8'd2;
        else if (v >= 8'd100) h = 8'd1;
        else h = 8'd0;
        return h;
    endfunction

    // Value below 100 after the hundreds are taken off
    function automatic logic [6:0] bcd_rem(input logic [7:0] v);
        logic [7:0] r;
        if (v >= 8'd200) r = v - 8'd200;
        else if (v >= 8'd100) r = v - 8'd100;
        else r = v;
        return r[6:0];
    endfunction

    // Tens of a value below 100: multiply by 205/2048
    function automatic logic [7:0] bcd_tens(input logic [7:0] v);
        logic [17:0] p;
        p = 18'(bcd_rem(v)) * 18'd205;
        return {4'd0, p[14:11]};
    endfunction

    function automatic logic [7:0] bcd_ones(input logic [7:0] v);
        logic [6:0] r;
        logic [7:0] t;
        r = bcd_rem(v);
        t = bcd_tens(v);
        return 8'(r) - ((t << 3) + (t << 1));
    endfunction

    // Highest pressed key
    function automatic logic [3:0] top_key(input logic [15:0] k);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (k[i]) idx = 4'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/c8x_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/c8x_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_front
// Accept items, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module c8x_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire c8x_pkg::t_in_item i_in_item,
    output logic                   o_q_valid,
    output c8x_pkg::t_cmd          o_q_cmd,
    input  wire logic              i_q_pop
);
    c8x_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    c8x_pkg::t_cls cls;
    logic [15:0]   op;
    logic          push;

    assign op = i_in_item.instruction;

    always_comb begin
        cls = c8x_pkg::CL_SIMPLE;
        unique case (i_in_item.action)
            c8x_pkg::ACT_MEMWR: cls = c8x_pkg::CL_MEMWR;
            c8x_pkg::ACT_ROWRD: cls = c8x_pkg::CL_ROWRD;
            c8x_pkg::ACT_EXEC: begin
                unique case (op[15:12])
                    c8x_pkg::OP_SYS: begin
                        if (op == c8x_pkg::OPW_CLS) cls = c8x_pkg::CL_CLEAR;
                        else if (op == c8x_pkg::OPW_RET) cls = c8x_pkg::CL_SIMPLE;
                        else cls = c8x_pkg::CL_BAD;
                    end
                    c8x_pkg::OP_SER, c8x_pkg::OP_SNER: begin
                        if (op[3:0] != 4'h0) cls = c8x_pkg::CL_BAD;
                    end
                    c8x_pkg::OP_ALU: begin
                        unique case (op[3:0]) inside
                            c8x_pkg::ALU_MOV, c8x_pkg::ALU_OR, c8x_pkg::ALU_AND,
                            c8x_pkg::ALU_XOR, c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB,
                            c8x_pkg::ALU_SHR, c8x_pkg::ALU_SBN, c8x_pkg::ALU_SHL:
                                cls = c8x_pkg::CL_SIMPLE;
                            default: cls = c8x_pkg::CL_BAD;
                        endcase
                    end
                    c8x_pkg::OP_DRW: cls = c8x_pkg::CL_DRAW;
                    c8x_pkg::OP_KEY: begin
                        if (op[7:0] != c8x_pkg::KEY_SKP && op[7:0] != c8x_pkg::KEY_SKNP)
                            cls = c8x_pkg::CL_BAD;
                    end
                    c8x_pkg::OP_MISC: begin
                        unique case (op[7:0]) inside
                            c8x_pkg::MSC_GDT, c8x_pkg::MSC_WKEY, c8x_pkg::MSC_SDT,
                            c8x_pkg::MSC_SST, c8x_pkg::MSC_ADDI, c8x_pkg::MSC_FONT:
                                cls = c8x_pkg::CL_SIMPLE;
                            c8x_pkg::MSC_BCD: cls = c8x_pkg::CL_BCD;
                            c8x_pkg::MSC_STR: cls = c8x_pkg::CL_STORE;
                            c8x_pkg::MSC_LDR: cls = c8x_pkg::CL_LOAD;
                            default: cls = c8x_pkg::CL_BAD;
                        endcase
                    end
                    default: cls = c8x_pkg::CL_SIMPLE;
                endcase
            end
            default: cls = c8x_pkg::CL_NOP;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cls: cls, item: i_in_item};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/c8x_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_back
// Execute classified items against the machine state; hold the result.
// ----------------------------------------------------------------------------
module c8x_back #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire c8x_pkg::t_cmd     i_q_cmd,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output c8x_pkg::t_out_item     o_out_item
);
    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    c8x_pkg::t_bstate   r_state, n_state;
    c8x_pkg::t_cmd      r_cmd, n_cmd;
    logic [7:0]         r_a, n_a, r_b, n_b;
    logic [11:0]        r_pc, n_pc;
    logic [15:0]        r_i, n_i;
    logic [SP_W-1:0]    r_sp, n_sp;
    logic [3:0]         r_cnt, n_cnt;
    logic               r_hit, n_hit;
    c8x_pkg::t_out_item r_res, n_res;
    logic               r_out_valid, n_out_valid;
    c8x_pkg::t_out_item r_out, n_out;

    logic [7:0]  r_v [16];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [63:0] r_screen [c8x_pkg::SCREEN_HEIGHT];
    logic [c8x_pkg::SCREEN_HEIGHT-1:0] r_row_nz;

    logic        v_we, vf_we, st_we, scr_we, scr_clr, mem_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, vf_wdata, v_rdata;
    logic [c8x_pkg::ROW_AW-1:0] scr_addr;
    logic [63:0] scr_wdata, scr_rdata;
    logic [c8x_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic [SP_W-1:0] sp_dec, sp_inc;

    logic [15:0] op;
    logic [3:0]  fx, fy, fn;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic [63:0] mask;
    logic [127:0] mask2;
    logic [11:0] pc2, pc4;

    assign op  = r_cmd.item.instruction;
    assign fx  = op[11:8];
    assign fy  = op[7:4];
    assign fn  = op[3:0];
    assign nn  = op[7:0];
    assign nnn = op[11:0];
    assign pc2 = r_pc + 12'd2;
    assign pc4 = r_pc + 12'd4;
    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - SP_W'(1);
    assign sp_inc = (r_sp == SP_LAST) ? '0 : r_sp + SP_W'(1);
    assign v_rdata   = r_v[v_raddr];
    assign scr_rdata = r_screen[scr_addr];
    assign mem_raddr = r_i[11:0] + {8'd0, r_cnt};
    assign mask2 = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> r_a[5:0];
    assign mask  = mask2[63:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_a = r_a; n_b = r_b;
        n_pc = r_pc; n_i = r_i; n_sp = r_sp; n_cnt = r_cnt; n_hit = r_hit;
        n_res = r_res; n_out_valid = r_out_valid; n_out = r_out;
        o_q_pop = 1'b0;
        v_we = 1'b0; v_waddr = fx; v_wdata = 8'd0;
        vf_we = 1'b0; vf_wdata = 8'd0;
        v_raddr = fx; st_we = 1'b0;
        scr_we = 1'b0; scr_clr = 1'b0; scr_wdata = 64'd0;
        scr_addr = r_cmd.item.address[c8x_pkg::ROW_AW-1:0];
        mem_we = 1'b0; mem_waddr = r_i[11:0] + {8'd0, r_cnt}; mem_wdata = 8'd0;
        sum9  = {1'b0, r_a} + {1'b0, r_b};
        sum17 = {1'b0, r_i} + {9'd0, r_a};

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        unique case (r_state)
            c8x_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_res   = '0;
                    n_cnt   = 4'd0;
                    n_hit   = 1'b0;
                    n_state = c8x_pkg::BS_DONE;
                    scr_addr = i_q_cmd.item.address[c8x_pkg::ROW_AW-1:0];
                    unique case (i_q_cmd.cls)
                        c8x_pkg::CL_MEMWR: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_q_cmd.item.address;
                            mem_wdata = i_q_cmd.item.data;
                        end
                        c8x_pkg::CL_ROWRD: n_res.row_pixels = scr_rdata;
                        c8x_pkg::CL_NOP: ;
                        c8x_pkg::CL_BAD: begin
                            n_res.bad_opcode = 1'b1;
                            n_pc = pc2;
                        end
                        c8x_pkg::CL_CLEAR: begin
                            scr_clr = 1'b1;
                            n_res.screen_changed = |r_row_nz;
                            n_pc = pc2;
                        end
                        default: n_state = c8x_pkg::BS_RDX;
                    endcase
                end
            end
            c8x_pkg::BS_RDX: begin
                v_raddr = fx;
                n_a = v_rdata;
                n_state = c8x_pkg::BS_RDY;
            end
            c8x_pkg::BS_RDY: begin
                v_raddr = fy;
                n_b = v_rdata;
                n_state = c8x_pkg::BS_EXEC;
            end
            c8x_pkg::BS_EXEC: begin
                n_state = c8x_pkg::BS_DONE;
                n_pc = pc2;
                unique case (r_cmd.cls)
                    c8x_pkg::CL_DRAW: begin
                        // Keep x coordinate in r_a, y row base in r_b
                        n_a = {2'd0, r_a[5:0]};
                        n_b = {3'd0, r_b[4:0]};
                        if (fn == 4'd0) begin
                            vf_we = 1'b1;
                        end else begin
                            n_pc = r_pc;
                            n_state = c8x_pkg::BS_DRAW_RD;
                        end
                    end
                    c8x_pkg::CL_BCD: begin
                        n_pc = r_pc;
                        n_state = c8x_pkg::BS_BCD;
                    end
                    c8x_pkg::CL_STORE: begin
                        n_pc = r_pc;
                        n_state = c8x_pkg::BS_STORE;
                    end
                    c8x_pkg::CL_LOAD: begin
                        n_pc = r_pc;
                        n_state = c8x_pkg::BS_LOAD_RD;
                    end
                    default: begin
                        unique case (op[15:12])
                            c8x_pkg::OP_SYS: begin
                                n_sp = sp_dec;
                                n_pc = r_stack[sp_dec] + 12'd2;
                            end
                            c8x_pkg::OP_JP: n_pc = nnn;
                            c8x_pkg::OP_CALL: begin
                                st_we = 1'b1;
                                n_sp = sp_inc;
                                n_pc = nnn;
                            end
                            c8x_pkg::OP_SEI:  n_pc = (r_a == nn) ? pc4 : pc2;
                            c8x_pkg::OP_SNEI: n_pc = (r_a != nn) ? pc4 : pc2;
                            c8x_pkg::OP_SER:  n_pc = (r_a == r_b) ? pc4 : pc2;
                            c8x_pkg::OP_SNER: n_pc = (r_a != r_b) ? pc4 : pc2;
                            c8x_pkg::OP_LDI: begin
                                v_we = 1'b1; v_wdata = nn;
                            end
                            c8x_pkg::OP_ADDI: begin
                                v_we = 1'b1; v_wdata = r_a + nn;
                            end
                            c8x_pkg::OP_ALU: begin
                                v_we = 1'b1;
                                unique case (fn)
                                    c8x_pkg::ALU_MOV: v_wdata = r_b;
                                    c8x_pkg::ALU_OR:  v_wdata = r_a | r_b;
                                    c8x_pkg::ALU_AND: v_wdata = r_a & r_b;
                                    c8x_pkg::ALU_XOR: v_wdata = r_a ^ r_b;
                                    c8x_pkg::ALU_ADD: begin
                                        v_wdata = sum9[7:0];
                                        vf_we = 1'b1; vf_wdata = {7'd0, sum9[8]};
                                    end
                                    c8x_pkg::ALU_SUB: begin
                                        v_wdata = r_a - r_b;
                                        vf_we = 1'b1; vf_wdata = {7'd0, r_a >= r_b};
                                    end
                                    c8x_pkg::ALU_SHR: begin
                                        v_wdata = {1'b0, r_a[7:1]};
                                        vf_we = 1'b1; vf_wdata = {7'd0, r_a[0]};
                                    end
                                    c8x_pkg::ALU_SBN: begin
                                        v_wdata = r_b - r_a;
                                        vf_we = 1'b1; vf_wdata = {7'd0, r_b >= r_a};
                                    end
                                    default: begin
                                        v_wdata = {r_a[6:0], 1'b0};
                                        vf_we = 1'b1; vf_wdata = {7'd0, r_a[7]};
                                    end
                                endcase
                            end
                            c8x_pkg::OP_LDIDX: n_i = {4'd0, nnn};
                            c8x_pkg::OP_JPV0: n_pc = nnn + {4'd0, r_v[0]};
                            c8x_pkg::OP_RND: begin
                                v_we = 1'b1;
                                v_wdata = r_cmd.item.random_byte & nn;
                            end
                            c8x_pkg::OP_KEY: begin
                                if (r_cmd.item.key_state[r_a[3:0]] ==
                                    (nn == c8x_pkg::KEY_SKP))
                                    n_pc = pc4;
                            end
                            default: begin
                                unique case (nn)
                                    c8x_pkg::MSC_GDT: begin
                                        v_we = 1'b1;
                                        v_wdata = r_cmd.item.delay_now;
                                    end
                                    c8x_pkg::MSC_WKEY: begin
                                        if (r_cmd.item.key_state == 16'd0) begin
                                            n_res.waiting_key = 1'b1;
                                            n_pc = r_pc;
                                        end else begin
                                            v_we = 1'b1;
                                            v_wdata = {4'd0,
                                                c8x_pkg::top_key(r_cmd.item.key_state)};
                                        end
                                    end
                                    c8x_pkg::MSC_SDT: begin
                                        n_res.delay_load  = 1'b1;
                                        n_res.timer_value = r_a;
                                    end
                                    c8x_pkg::MSC_SST: begin
                                        n_res.sound_load  = 1'b1;
                                        n_res.timer_value = r_a;
                                    end
                                    c8x_pkg::MSC_ADDI: begin
                                        n_i = sum17[15:0];
                                        vf_we = 1'b1;
                                        vf_wdata = {7'd0, sum17 > 17'h00FFF};
                                    end
                                    default: n_i = {6'd0, r_a, 2'd0} + {8'd0, r_a};
                                endcase
                            end
                        endcase
                    end
                endcase
            end
            c8x_pkg::BS_DRAW_RD: n_state = c8x_pkg::BS_DRAW_WR;
            c8x_pkg::BS_DRAW_WR: begin
                // XOR one sprite row into the screen, wrapping at the bottom
                scr_addr  = r_b[4:0] + {1'b0, r_cnt};
                scr_we    = 1'b1;
                scr_wdata = scr_rdata ^ mask;
                n_hit = r_hit | (|(scr_rdata & mask));
                if (mask != 64'd0) n_res.screen_changed = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == fn - 4'd1) begin
                    vf_we = 1'b1;
                    vf_wdata = {7'd0, n_hit};
                    n_pc = pc2;
                    n_state = c8x_pkg::BS_DONE;
                end else begin
                    n_state = c8x_pkg::BS_DRAW_RD;
                end
            end
            c8x_pkg::BS_BCD: begin
                mem_we = 1'b1;
                if (r_cnt == 4'd0) mem_wdata = c8x_pkg::bcd_hund(r_a);
                else if (r_cnt == 4'd1) mem_wdata = c8x_pkg::bcd_tens(r_a);
                else mem_wdata = c8x_pkg::bcd_ones(r_a);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) begin
                    n_pc = pc2;
                    n_state = c8x_pkg::BS_DONE;
                end
            end
            c8x_pkg::BS_STORE: begin
                v_raddr = r_cnt;
                mem_we = 1'b1;
                mem_wdata = v_rdata;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == fx) begin
                    n_i = r_i + {12'd0, fx} + 16'd1;
                    n_pc = pc2;
                    n_state = c8x_pkg::BS_DONE;
                end
            end
            c8x_pkg::BS_LOAD_RD: n_state = c8x_pkg::BS_LOAD_WR;
            c8x_pkg::BS_LOAD_WR: begin
                v_we = 1'b1;
                v_waddr = r_cnt;
                v_wdata = mem_rdata;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == fx) begin
                    n_i = r_i + {12'd0, fx} + 16'd1;
                    n_pc = pc2;
                    n_state = c8x_pkg::BS_DONE;
                end else begin
                    n_state = c8x_pkg::BS_LOAD_RD;
                end
            end
            default: begin
                // Hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out = r_res;
                    n_out.next_pc = r_pc;
                    n_out_valid = 1'b1;
                    n_state = c8x_pkg::BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_a <= n_a; r_b <= n_b; r_cnt <= n_cnt;
        r_hit <= n_hit; r_res <= n_res; r_out <= n_out;
        if (st_we) r_stack[r_sp] <= r_pc;
        if (!i_rst_n) begin
            r_state     <= c8x_pkg::BS_IDLE;
            r_pc        <= c8x_pkg::PC_RESET;
            r_i         <= 16'd0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            r_row_nz    <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < c8x_pkg::SCREEN_HEIGHT; k++) r_screen[k] <= 64'd0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_i         <= n_i;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            // The flag write wins over a result aimed at VF
            if (v_we && !(vf_we && v_waddr == 4'hF)) r_v[v_waddr] <= v_wdata;
            if (vf_we) r_v[15] <= vf_wdata;
            if (scr_clr) begin
                r_row_nz <= '0;
                for (int k = 0; k < c8x_pkg::SCREEN_HEIGHT; k++) r_screen[k] <= 64'd0;
            end else if (scr_we) begin
                r_screen[scr_addr] <= scr_wdata;
                r_row_nz[scr_addr] <= |scr_wdata;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chip8_instruction_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute unit: a front end classifies and queues items, a back end
// runs them against registers, stack, 4 KB memory and a 64x32 screen.
// ----------------------------------------------------------------------------
// Sequence: memory writes, row reads, clears and bad opcodes are done on pickup;
//   other instructions read Vx, then Vy, then execute; draws then read and
//   XOR each sprite row, BCD writes three digits, store and load move V0-Vx.
// The back end sequencer handles one item at a time, while the front end queue
//   holds up to two more; the memory port serves one byte per cycle.
// Reset: synchronous, active low; clears V0-VF, I, stack pointer and screen,
//   sets PC to 0x200. Memory and stack contents are left as they are.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire c8x_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output c8x_pkg::t_out_item      o_out_item
);
    // Queue between the classifier and the sequencer
    logic          q_valid;
    logic          q_pop;
    c8x_pkg::t_cmd q_cmd;

    // Front end: accept and classify each item
    c8x_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // Back end: execute and hold the result in the output register
    c8x_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );
endmodule
`default_nettype wire

// ===== dv/tb_chip8_instruction_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute
// Self-checking bench for the CHIP-8 execute unit. It preloads a window of
// memory, runs a directed opcode sweep, then random programs with random
// stalls on both channels. A behavioral CPU copy predicts every result item.
// ----------------------------------------------------------------------------

// Behavioral copy of the CPU state; predicts result items in order.
class cpu_shadow;
    bit [7:0]  vreg [16];
    bit [15:0] ireg;
    bit [11:0] pc;
    bit [11:0] stk [16];
    bit        stk_set [16];
    bit [3:0]  sp;
    bit [7:0]  mem [4096];
    bit        mem_set [4096];
    bit [63:0] scr [32];
    c8x_pkg::t_out_item pending_q [$];
    int        errors;
    int        n_checked;
    int        n_exec;
    int        n_draw;

    function new();
        foreach (vreg[i]) vreg[i] = '0;
        foreach (stk_set[i]) stk_set[i] = 1'b0;
        foreach (mem_set[i]) mem_set[i] = 1'b0;
        foreach (scr[i]) scr[i] = '0;
        ireg = '0;
        pc = c8x_pkg::PC_RESET;
        sp = '0;
    endfunction

    // A return is only legal when the slot it pops has been written.
    function bit ret_ok();
        return stk_set[sp - 4'd1];
    endfunction

    // Draws and register loads may only read bytes that were written.
    function bit rd_ok(logic [15:0] op);
        int cnt;
        cnt = 0;
        if (op[15:12] == c8x_pkg::OP_DRW) cnt = int'(op[3:0]);
        else if (op[15:12] == c8x_pkg::OP_MISC && op[7:0] == c8x_pkg::MSC_LDR)
            cnt = int'(op[11:8]) + 1;
        for (int i = 0; i < cnt; i++) begin
            if (!mem_set[12'(ireg + i)]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void mem_put(bit [11:0] addr, bit [7:0] val);
        mem[addr] = val;
        mem_set[addr] = 1'b1;
    endfunction

    function void note(c8x_pkg::t_in_item it);
        c8x_pkg::t_out_item r;
        bit [3:0]  x, y, n;
        bit [7:0]  a, b, nn, bits, res;
        bit [8:0]  wide;
        bit [16:0] s17;
        bit [63:0] mask;
        bit        bad, flag, hasflag, hit;
        int        cx, cy, row;
        r = '0;
        x = it.instruction[11:8];
        y = it.instruction[7:4];
        n = it.instruction[3:0];
        nn = it.instruction[7:0];
        a = vreg[x];
        b = vreg[y];
        bad = 0;
        if (it.action == c8x_pkg::ACT_MEMWR) begin
            mem_put(it.address, it.data);
        end else if (it.action == c8x_pkg::ACT_ROWRD) begin
            r.row_pixels = scr[it.address[4:0]];
        end else if (it.action == c8x_pkg::ACT_EXEC) begin
            n_exec++;
            case (it.instruction[15:12])
                c8x_pkg::OP_SYS: begin
                    if (it.instruction == c8x_pkg::OPW_CLS) begin
                        foreach (scr[i]) begin
                            if (scr[i] != 0) r.screen_changed = 1;
                            scr[i] = '0;
                        end
                        pc += 12'd2;
                    end else if (it.instruction == c8x_pkg::OPW_RET) begin
                        sp -= 4'd1;
                        pc = stk[sp] + 12'd2;
                    end else bad = 1;
                end
                c8x_pkg::OP_JP: pc = it.instruction[11:0];
                c8x_pkg::OP_CALL: begin
                    stk[sp] = pc;
                    stk_set[sp] = 1;
                    sp += 4'd1;
                    pc = it.instruction[11:0];
                end
                c8x_pkg::OP_SEI:  pc += (a == nn) ? 12'd4 : 12'd2;
                c8x_pkg::OP_SNEI: pc += (a != nn) ? 12'd4 : 12'd2;
                c8x_pkg::OP_SER:
                    if (n != 0) bad = 1; else pc += (a == b) ? 12'd4 : 12'd2;
                c8x_pkg::OP_SNER:
                    if (n != 0) bad = 1; else pc += (a != b) ? 12'd4 : 12'd2;
                c8x_pkg::OP_LDI: begin vreg[x] = nn; pc += 12'd2; end
                c8x_pkg::OP_ADDI: begin vreg[x] = a + nn; pc += 12'd2; end
                c8x_pkg::OP_ALU: begin
                    hasflag = 1;
                    flag = 0;
                    res = 0;
                    case (n)
                        c8x_pkg::ALU_MOV: begin res = b; hasflag = 0; end
                        c8x_pkg::ALU_OR:  begin res = a | b; hasflag = 0; end
                        c8x_pkg::ALU_AND: begin res = a & b; hasflag = 0; end
                        c8x_pkg::ALU_XOR: begin res = a ^ b; hasflag = 0; end
                        c8x_pkg::ALU_ADD: begin
                            wide = {1'b0, a} + {1'b0, b}; res = wide[7:0]; flag = wide[8];
                        end
                        c8x_pkg::ALU_SUB: begin res = a - b; flag = (a >= b); end
                        c8x_pkg::ALU_SHR: begin res = a >> 1; flag = a[0]; end
                        c8x_pkg::ALU_SBN: begin res = b - a; flag = (b >= a); end
                        c8x_pkg::ALU_SHL: begin res = a << 1; flag = a[7]; end
                        default: bad = 1;
                    endcase
                    if (!bad) begin
                        vreg[x] = res;
                        if (hasflag) vreg[15] = {7'd0, flag};
                        pc += 12'd2;
                    end
                end
                c8x_pkg::OP_LDIDX: begin
                    ireg = {4'd0, it.instruction[11:0]}; pc += 12'd2;
                end
                c8x_pkg::OP_JPV0: pc = it.instruction[11:0] + {4'd0, vreg[0]};
                c8x_pkg::OP_RND: begin vreg[x] = it.random_byte & nn; pc += 12'd2; end
                c8x_pkg::OP_DRW: begin
                    n_draw++;
                    cx = a % 64;
                    cy = b % 32;
                    hit = 0;
                    for (int rr = 0; rr < n; rr++) begin
                        bits = mem[12'(ireg + rr)];
                        row = (cy + rr) % 32;
                        mask = '0;
                        for (int c = 0; c < 8; c++)
                            if (bits[7 - c]) mask[63 - ((cx + c) % 64)] = 1;
                        if ((scr[row] & mask) != 0) hit = 1;
                        if (mask != 0) r.screen_changed = 1;
                        scr[row] ^= mask;
                    end
                    vreg[15] = {7'd0, hit};
                    pc += 12'd2;
                end
                c8x_pkg::OP_KEY: begin
                    if (nn == c8x_pkg::KEY_SKP)
                        pc += it.key_state[a[3:0]] ? 12'd4 : 12'd2;
                    else if (nn == c8x_pkg::KEY_SKNP)
                        pc += it.key_state[a[3:0]] ? 12'd2 : 12'd4;
                    else bad = 1;
                end
                default: begin
                    case (nn)
                        c8x_pkg::MSC_GDT: begin vreg[x] = it.delay_now; pc += 12'd2; end
                        c8x_pkg::MSC_WKEY: begin
                            if (it.key_state == 0) r.waiting_key = 1;
                            else begin
                                for (int k = 0; k < 16; k++)
                                    if (it.key_state[k]) vreg[x] = 8'(k);
                                pc += 12'd2;
                            end
                        end
                        c8x_pkg::MSC_SDT: begin
                            r.delay_load = 1; r.timer_value = a; pc += 12'd2;
                        end
                        c8x_pkg::MSC_SST: begin
                            r.sound_load = 1; r.timer_value = a; pc += 12'd2;
                        end
                        c8x_pkg::MSC_ADDI: begin
                            s17 = {1'b0, ireg} + {9'd0, a};
                            ireg = s17[15:0];
                            vreg[15] = {7'd0, s17 > 17'hFFF};
                            pc += 12'd2;
                        end
                        c8x_pkg::MSC_FONT: begin ireg = a * 16'd5; pc += 12'd2; end
                        c8x_pkg::MSC_BCD: begin
                            mem_put(12'(ireg), a / 8'd100);
                            mem_put(12'(ireg + 1), (a / 8'd10) % 8'd10);
                            mem_put(12'(ireg + 2), a % 8'd10);
                            pc += 12'd2;
                        end
                        c8x_pkg::MSC_STR: begin
                            for (int i = 0; i <= x; i++) mem_put(12'(ireg + i), vreg[i]);
                            ireg += {12'd0, x} + 16'd1;
                            pc += 12'd2;
                        end
                        c8x_pkg::MSC_LDR: begin
                            for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + i)];
                            ireg += {12'd0, x} + 16'd1;
                            pc += 12'd2;
                        end
                        default: bad = 1;
                    endcase
                end
            endcase
            if (bad) pc += 12'd2;
        end
        r.next_pc = pc;
        r.bad_opcode = bad;
        pending_q.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] g);
        if (e !== g) begin
            errors++;
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, e, g);
        end
    endfunction

    function void check(c8x_pkg::t_out_item got);
        c8x_pkg::t_out_item e;
        if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item: expected none, got %h", $time, got);
            return;
        end
        e = pending_q.pop_front();
        n_checked++;
        cmp("next_pc", 64'(e.next_pc), 64'(got.next_pc));
        cmp("waiting_key", 64'(e.waiting_key), 64'(got.waiting_key));
        cmp("delay_load", 64'(e.delay_load), 64'(got.delay_load));
        cmp("sound_load", 64'(e.sound_load), 64'(got.sound_load));
        cmp("timer_value", 64'(e.timer_value), 64'(got.timer_value));
        cmp("screen_changed", 64'(e.screen_changed), 64'(got.screen_changed));
        cmp("bad_opcode", 64'(e.bad_opcode), 64'(got.bad_opcode));
        cmp("row_pixels", e.row_pixels, got.row_pixels);
    endfunction
endclass

module tb_chip8_instruction_execute;

    localparam int WATCHDOG_LIMIT = 5000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      in_valid = 0;
    logic      out_ready = 0;
    c8x_pkg::t_in_item  in_item = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    c8x_pkg::t_out_item o_out_item;

    cpu_shadow shadow = new();
    bit        calm = 0;      // when set, neither side idles
    bit        hold_done = 0;
    int        hold_cnt = 0;
    int        quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    chip8_instruction_execute u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // Monitor the result channel and count cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) shadow.check(o_out_item);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off so the unit backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 0;
        end else if (!hold_done && shadow.n_checked >= 250) begin
            hold_done = 1;
            hold_cnt = 400;
            out_ready <= 0;
        end else begin
            out_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    // Offer one item; drop valid only when idling first, then hold until taken.
    // The shadow notes the item at the edge that accepts it.
    task automatic send(c8x_pkg::t_in_item it);
        if (!calm && $urandom_range(0, 99) < 19) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1;
        in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.note(it);
    endtask

    task automatic exec(logic [15:0] op, logic [15:0] keys);
        c8x_pkg::t_in_item it;
        it.action = c8x_pkg::ACT_EXEC;
        it.instruction = op;
        it.key_state = keys;
        it.random_byte = 8'($urandom);
        it.delay_now = 8'($urandom);
        it.address = 12'($urandom);
        it.data = 8'($urandom);
        if (op == c8x_pkg::OPW_RET && !shadow.ret_ok()) it.instruction = c8x_pkg::OPW_CLS;
        if (!shadow.rd_ok(it.instruction)) begin
            // Draw nothing, or store instead of load, when bytes are unwritten
            if (it.instruction[15:12] == c8x_pkg::OP_DRW) it.instruction[3:0] = 4'd0;
            else it.instruction[7:0] = c8x_pkg::MSC_STR;
        end
        send(it);
    endtask

    task automatic mem_write(logic [11:0] addr, logic [7:0] val);
        c8x_pkg::t_in_item it;
        it = '0;
        it.action = c8x_pkg::ACT_MEMWR;
        it.address = addr;
        it.data = val;
        it.instruction = 16'($urandom);
        send(it);
    endtask

    task automatic other_action(logic [1:0] act);
        c8x_pkg::t_in_item it;
        it = c8x_pkg::t_in_item'(70'({$urandom, $urandom, $urandom}));
        it.action = act;
        send(it);
    endtask

    // Build a well-formed opcode of a random group, with a few malformed ones.
    function automatic logic [15:0] pick_opcode();
        logic [3:0] x, y;
        logic [7:0] nn;
        logic [3:0] alu_ops [9] = '{c8x_pkg::ALU_MOV, c8x_pkg::ALU_OR, c8x_pkg::ALU_AND,
                                    c8x_pkg::ALU_XOR, c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB,
                                    c8x_pkg::ALU_SHR, c8x_pkg::ALU_SBN, c8x_pkg::ALU_SHL};
        logic [7:0] msc_ops [9] = '{c8x_pkg::MSC_GDT, c8x_pkg::MSC_WKEY, c8x_pkg::MSC_SDT,
                                    c8x_pkg::MSC_SST, c8x_pkg::MSC_ADDI, c8x_pkg::MSC_FONT,
                                    c8x_pkg::MSC_BCD, c8x_pkg::MSC_STR, c8x_pkg::MSC_LDR};
        x = 4'($urandom);
        y = 4'($urandom);
        nn = 8'($urandom);
        case ($urandom_range(0, 19))
            0:  return c8x_pkg::OPW_CLS;
            1:  return c8x_pkg::OPW_RET;
            2:  return {c8x_pkg::OP_JP, 12'($urandom)};
            3:  return {c8x_pkg::OP_CALL, 12'($urandom)};
            4:  return {c8x_pkg::OP_SEI, x, nn};
            5:  return {c8x_pkg::OP_SNEI, x, nn};
            6:  return {c8x_pkg::OP_SER, x, y, 4'd0};
            7:  return {c8x_pkg::OP_SNER, x, y, 4'd0};
            8, 9: return {c8x_pkg::OP_LDI, x, nn};
            10: return {c8x_pkg::OP_ADDI, x, nn};
            11, 12: return {c8x_pkg::OP_ALU, x, y, alu_ops[$urandom_range(0, 8)]};
            13: return {c8x_pkg::OP_LDIDX, 12'($urandom_range(0, 24))};
            14: return {c8x_pkg::OP_JPV0, 12'($urandom)};
            15: return {c8x_pkg::OP_RND, x, nn};
            16: return {c8x_pkg::OP_DRW, x, y, 4'($urandom_range(0, 6))};
            17: return {c8x_pkg::OP_KEY, x,
                        $urandom_range(0, 1) ? c8x_pkg::KEY_SKP : c8x_pkg::KEY_SKNP};
            18: return {c8x_pkg::OP_MISC, x, msc_ops[$urandom_range(0, 8)]};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] directed [] = '{
            c8x_pkg::OPW_CLS, 16'h60FF, 16'h61FF, 16'h8014, 16'h6F80, 16'h8FF4, 16'h8015,
            16'h8017, 16'h8016, 16'h801E, 16'h6A3F, 16'h6B1F, 16'hAFFE, 16'hDAB5,
            16'hDAB5, 16'hDAB0, 16'h2ABC, c8x_pkg::OPW_RET, 16'h0123, 16'h5121, 16'h8128,
            16'hE0FF, 16'hF0FF, 16'hF11E, 16'hF033, 16'hFF55, 16'hFF65, 16'hB123};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Preload a window of memory that wraps round the top address.
        for (int a = 0; a < 64; a++) mem_write(12'(12'hFE0 + a), 8'($urandom));

        // Directed sweep: carries, borrows, wrapped and empty draws, bad forms.
        foreach (directed[i]) exec(directed[i], 16'h0000);
        exec(16'hF50A, 16'h0000);
        exec(16'hF50A, 16'h8001);
        exec(16'hE59E, 16'hFFFF);
        exec(16'hE5A1, 16'h0000);
        exec(16'hF515, 16'h0000);
        exec(16'hF518, 16'h0000);
        exec(16'hF507, 16'h0000);
        exec(16'hF529, 16'h0000);
        other_action(2'd3);
        other_action(c8x_pkg::ACT_ROWRD);

        // Random programs; a quiet stretch with no idling in the middle.
        for (int k = 0; k < 400; k++) begin
            int sel;
            calm = (k >= 200 && k < 280);
            sel = $urandom_range(0, 99);
            if (sel < 6) mem_write(12'($urandom), 8'($urandom));
            else if (sel < 14) other_action(c8x_pkg::ACT_ROWRD);
            else if (sel < 16) other_action(2'd3);
            else exec(pick_opcode(), $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom));
        end
        in_valid <= 0;
        calm = 0;

        while (shadow.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d result items: %0d instructions executed, %0d sprite draws",
                 shadow.n_checked, shadow.n_exec, shadow.n_draw);
        if (shadow.errors == 0 && shadow.pending_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
